FILE: rtl/quicksort_engine_unit_defines.svh
// Assertion macros shared by the quicksort engine RTL.
`ifndef QUICKSORT_ENGINE_UNIT_DEFINES_SVH
`define QUICKSORT_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define QS_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define QS_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define QS_ASSERT(label, clk, rst_n, prop)
`define QS_ASSERT_NORST(label, clk, prop)
`endif
`endif

FILE: rtl/qse_pkg.sv
// ----------------------------------------------------------------------------
// qse_pkg
// Shared constants and types for the quicksort engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package qse_pkg;
  localparam int MaxElements = 64;
  localparam int IdxW = $clog2(MaxElements);
  localparam int CntW = IdxW + 1;
  localparam int DataW = 32;

  // Memory port request from the controller to the element store.
  typedef struct packed {
    logic             wr_en;
    logic [IdxW-1:0]  wr_addr;
    logic [DataW-1:0] wr_data;
    logic [IdxW-1:0]  rd_addr;
  } mem_req_t;
endpackage

FILE: rtl/qse_mem.sv
// ----------------------------------------------------------------------------
// qse_mem
// Element store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qse_mem (
  input  logic                     clk,
  input  qse_pkg::mem_req_t        req,
  output logic [qse_pkg::DataW-1:0] rd_data
);
  import qse_pkg::*;

  logic [DataW-1:0] mem_r [MaxElements];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
    rd_data <= mem_r[req.rd_addr];
  end
endmodule

FILE: rtl/qse_stack.sv
// ----------------------------------------------------------------------------
// qse_stack
// Range stack memory holding packed begin/end pairs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module qse_stack (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [qse_pkg::IdxW-1:0]      wr_addr,
  input  logic [2*qse_pkg::IdxW-1:0]    wr_data,
  input  logic [qse_pkg::IdxW-1:0]      rd_addr,
  output logic [2*qse_pkg::IdxW-1:0]    rd_data
);
  import qse_pkg::*;

  logic [2*IdxW-1:0] stk_r [MaxElements];

  // Synchronous write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      stk_r[wr_addr] <= wr_data;
    end
    rd_data <= stk_r[rd_addr];
  end
endmodule

FILE: rtl/quicksort_engine_unit.sv
// ----------------------------------------------------------------------------
// quicksort_engine_unit
// Loads up to 64 signed values, sorts them in place by quicksort and emits them.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake
// in_*      input      start & !busy
// out_*     output     out_valid strobe, one cycle, no stall
//
// Loading accepts one element per cycle while start is high. After the last
// element the sort runs on the element store with a single read port: each
// compare reads the scanned element and then tests it, each swap writes the
// store twice, and each range is popped and its parts pushed. Ordered input is
// the worst case for the sort. Emission then reads each element from the store
// and strobes it out. busy is high from the last element and drops in the cycle
// after the final result. Reset is synchronous and clears control only.
`timescale 1ns / 1ps
`include "quicksort_engine_unit_defines.svh"
module quicksort_engine_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic signed [31:0]         in_value,
  input  logic                       in_is_last,
  output logic                       out_valid,
  output logic signed [31:0]         out_sorted_value,
  output logic                       out_last_out
);
  import qse_pkg::*;

  localparam logic [3:0] S_LOAD = 4'd0;
  localparam logic [3:0] S_POP = 4'd1;
  localparam logic [3:0] S_POPW = 4'd2;
  localparam logic [3:0] S_RDL = 4'd3;
  localparam logic [3:0] S_RDS = 4'd4;
  localparam logic [3:0] S_CMP = 4'd5;
  localparam logic [3:0] S_SWP = 4'd6;
  localparam logic [3:0] S_PUSH = 4'd7;
  localparam logic [3:0] S_EMRD = 4'd8;
  localparam logic [3:0] S_EMOUT = 4'd9;

  logic [3:0] st_r, st_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;
  logic [CntW-1:0] sp_r, sp_nxt;
  logic [IdxW-1:0] beg_r, beg_nxt, end_r, end_nxt;
  logic [IdxW-1:0] loc_r, loc_nxt, lft_r, lft_nxt, rgt_r, rgt_nxt;
  logic dir_r, dir_nxt;      // 0: scanning from the right, 1: from the left
  logic [DataW-1:0] pv_r, pv_nxt;  // pivot value held at loc
  logic [DataW-1:0] sv_r, sv_nxt;  // scanned value
  logic [1:0] pq_r, pq_nxt;  // pending pushes: bit1 right part, bit0 left part
  logic [CntW-1:0] k_r, k_nxt;
  mem_req_t req;
  logic [DataW-1:0] rd_data;
  logic stk_we;
  logic [IdxW-1:0] stk_wa, stk_ra;
  logic [2*IdxW-1:0] stk_wd, stk_rd;
  logic ov_nxt, ol_nxt;
  logic [DataW-1:0] od_nxt;
  logic [IdxW-1:0] scan_idx;
  logic in_order;

  qse_mem u_mem (.clk(clk), .req(req), .rd_data(rd_data));
  qse_stack u_stk (.clk(clk), .wr_en(stk_we), .wr_addr(stk_wa), .wr_data(stk_wd),
                   .rd_addr(stk_ra), .rd_data(stk_rd));

  assign busy = (st_r != S_LOAD);
  assign scan_idx = dir_r ? lft_r : rgt_r;
  // Right scan continues while pivot <= element; left while pivot >= element.
  assign in_order = dir_r ? !($signed(pv_r) < $signed(sv_r))
                          : !($signed(sv_r) < $signed(pv_r));

  // Sequencer for load, partition, stack and emission.
  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; sp_nxt = sp_r; beg_nxt = beg_r; end_nxt = end_r;
    loc_nxt = loc_r; lft_nxt = lft_r; rgt_nxt = rgt_r; dir_nxt = dir_r;
    pv_nxt = pv_r; sv_nxt = sv_r; pq_nxt = pq_r; k_nxt = k_r;
    req = '0; stk_we = 1'b0; stk_wa = sp_r[IdxW-1:0]; stk_wd = '0;
    stk_ra = sp_r[IdxW-1:0] - 1'b1;
    ov_nxt = 1'b0; ol_nxt = 1'b0; od_nxt = rd_data;
    unique case (st_r)
      S_LOAD: begin
        if (start) begin
          req.wr_addr = cnt_r[IdxW-1:0];
          req.wr_data = in_value;
          req.wr_en = (cnt_r < CntW'(MaxElements));
          cnt_nxt = cnt_r + CntW'(req.wr_en);
          if (in_is_last) begin
            k_nxt = '0;
            if (cnt_nxt >= CntW'(2)) begin
              stk_we = 1'b1; stk_wa = '0;
              stk_wd = {IdxW'(0), IdxW'(cnt_nxt - 1'b1)};
              sp_nxt = CntW'(1);
              st_nxt = S_POP;
            end else begin
              sp_nxt = '0;
              st_nxt = S_EMRD;
            end
          end
        end
      end
      S_POP: begin
        if (sp_r == '0) begin
          st_nxt = S_EMRD; k_nxt = '0;
        end else begin
          sp_nxt = sp_r - 1'b1;
          st_nxt = S_POPW;
        end
      end
      S_POPW: begin
        beg_nxt = stk_rd[2*IdxW-1:IdxW]; end_nxt = stk_rd[IdxW-1:0];
        loc_nxt = beg_nxt; lft_nxt = beg_nxt; rgt_nxt = end_nxt; dir_nxt = 1'b0;
        req.rd_addr = beg_nxt;
        st_nxt = S_RDL;
      end
      S_RDL: begin
        pv_nxt = rd_data;
        req.rd_addr = scan_idx;
        st_nxt = S_RDS;
      end
      S_RDS: begin
        sv_nxt = rd_data;
        st_nxt = S_CMP;
      end
      S_CMP: begin
        if (scan_idx == loc_r) begin
          // Only parts of two or more elements are pushed.
          pq_nxt = {loc_r < end_r - 1'b1, beg_r + 1'b1 < loc_r};
          st_nxt = S_PUSH;
        end else if (in_order) begin
          if (dir_r) lft_nxt = lft_r + 1'b1; else rgt_nxt = rgt_r - 1'b1;
          req.rd_addr = dir_r ? lft_nxt : rgt_nxt;
          st_nxt = S_RDS;
        end else begin
          // Move the scanned element into the pivot's slot.
          req.wr_en = 1'b1; req.wr_addr = loc_r; req.wr_data = sv_r;
          st_nxt = S_SWP;
        end
      end
      S_SWP: begin
        // Place the pivot at the scan position, then scan from the other side.
        req.wr_en = 1'b1; req.wr_addr = scan_idx; req.wr_data = pv_r;
        loc_nxt = scan_idx;
        dir_nxt = !dir_r;
        req.rd_addr = dir_r ? rgt_r : lft_r;
        st_nxt = S_RDS;
      end
      S_PUSH: begin
        if (pq_r[1]) begin
          stk_we = 1'b1; stk_wd = {IdxW'(loc_r + 1'b1), end_r};
          sp_nxt = sp_r + 1'b1; pq_nxt[1] = 1'b0;
        end else if (pq_r[0]) begin
          stk_we = 1'b1; stk_wd = {beg_r, IdxW'(loc_r - 1'b1)};
          sp_nxt = sp_r + 1'b1; pq_nxt[0] = 1'b0;
        end else begin
          st_nxt = S_POP;
        end
      end
      S_EMRD: begin
        if (k_r == cnt_r) begin
          cnt_nxt = '0; st_nxt = S_LOAD;
        end else begin
          req.rd_addr = k_r[IdxW-1:0];
          st_nxt = S_EMOUT;
        end
      end
      S_EMOUT: begin
        ov_nxt = 1'b1; od_nxt = rd_data;
        ol_nxt = (k_r + 1'b1 == cnt_r);
        k_nxt = k_r + 1'b1;
        st_nxt = S_EMRD;
      end
      default: st_nxt = S_LOAD;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_LOAD; cnt_r <= '0; sp_r <= '0; out_valid <= 1'b0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; sp_r <= sp_nxt; out_valid <= ov_nxt;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    beg_r <= beg_nxt; end_r <= end_nxt; loc_r <= loc_nxt; lft_r <= lft_nxt;
    rgt_r <= rgt_nxt; dir_r <= dir_nxt; pv_r <= pv_nxt; sv_r <= sv_nxt;
    pq_r <= pq_nxt; k_r <= k_nxt;
    out_sorted_value <= od_nxt; out_last_out <= ol_nxt;
  end

  `QS_ASSERT(a_cnt_max, clk, rst_n, cnt_r <= CntW'(MaxElements))
  `QS_ASSERT(a_sp_max, clk, rst_n, sp_r <= CntW'(MaxElements))
  `QS_ASSERT(a_out_busy, clk, rst_n, out_valid |-> $past(busy))
  `QS_ASSERT(a_last_idle, clk, rst_n, (out_valid && out_last_out) |=> !busy)
endmodule

FILE: test/tb_quicksort_engine_unit.sv
// ----------------------------------------------------------------------------
// tb_quicksort_engine_unit
// Self-checking testbench for the quicksort engine.
// Sets of signed values are loaded through the command port with random gaps.
// A local model gathers each set, sorts it ascending and queues the expected
// output. Every strobed result is checked against the oldest expected entry.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_quicksort_engine_unit;
  import qse_pkg::*;

  localparam int CycleLimit = 1000000;
  localparam int DrainCycles = 64;

  typedef struct {
    logic signed [DataW-1:0] value;
    logic                    last;
  } sorted_entry_t;

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    start;
  logic                    busy;
  logic signed [DataW-1:0] in_value;
  logic                    in_is_last;
  logic                    out_valid;
  logic signed [DataW-1:0] out_sorted_value;
  logic                    out_last_out;

  logic signed [DataW-1:0] held_set[$];
  sorted_entry_t           sorted_q[$];
  int                      mismatches;
  int                      cycles;
  bit                      no_gaps;

  quicksort_engine_unit dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .start            (start),
    .busy             (busy),
    .in_value         (in_value),
    .in_is_last       (in_is_last),
    .out_valid        (out_valid),
    .out_sorted_value (out_sorted_value),
    .out_last_out     (out_last_out)
  );

  // Clock with a 4 ns period.
  always begin
    #2;
    clk = 1'b1;
    #2;
    clk = 1'b0;
  end

  // Guard against a hung block.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Model of the engine: gather the set, then queue it in ascending order.
  task automatic record_element(input logic signed [DataW-1:0] v, input logic last);
    logic signed [DataW-1:0] ordered[$];
    logic signed [DataW-1:0] tmp;
    sorted_entry_t           e;
    int                      j;
    if (held_set.size() < MaxElements) held_set.push_back(v);
    if (last) begin
      ordered = held_set;
      for (int i = 1; i < ordered.size(); i++) begin
        tmp = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > tmp) begin
          ordered[j + 1] = ordered[j];
          j--;
        end
        ordered[j + 1] = tmp;
      end
      foreach (ordered[k]) begin
        e.value = ordered[k];
        e.last  = (k == ordered.size() - 1);
        sorted_q.push_back(e);
      end
      held_set.delete();
    end
  endtask

  // Send one element as a transaction; start stays high after acceptance.
  task automatic send_element(input logic signed [DataW-1:0] v, input logic last);
    int gap;
    bit taken;
    gap = no_gaps ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    start      = 1'b1;
    in_value   = v;
    in_is_last = last;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    record_element(v, last);
    @(negedge clk);
  endtask

  // Hold the input off until every expected result has come out.
  task automatic wait_drained();
    start = 1'b0;
    while (sorted_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  // Check each strobed result against the oldest expected entry.
  always @(posedge clk) begin
    sorted_entry_t e;
    if (rst_n && out_valid) begin
      if (sorted_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: value %0d last %0b", out_sorted_value, out_last_out);
      end else begin
        e = sorted_q.pop_front();
        if (out_sorted_value !== e.value || out_last_out !== e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %0d/%0b, got %0d/%0b",
                     e.value, e.last, out_sorted_value, out_last_out);
        end
      end
    end
  end

  // Single element, pairs, extremes, duplicates and ordered inputs.
  task automatic test_directed();
    send_element(32'sd5, 1'b1);
    send_element(32'sh7FFFFFFF, 1'b0);
    send_element(32'sh80000000, 1'b1);
    send_element(-32'sd1, 1'b0);
    send_element(32'sd0, 1'b0);
    send_element(32'sh7FFFFFFF, 1'b0);
    send_element(32'sh80000000, 1'b0);
    send_element(32'sd1, 1'b1);
    for (int i = 0; i < 5; i++) send_element(32'sd7, i == 4);
    for (int i = 0; i < 5; i++) send_element(i, i == 4);
    for (int i = 0; i < 5; i++) send_element(10 - i, i == 4);
  endtask

  // Fill past capacity: extra elements are dropped, the last one still closes the set.
  task automatic test_store_full();
    wait_drained();
    for (int i = 0; i < MaxElements + 3; i++)
      send_element($urandom(), i == MaxElements + 2);
  endtask

  // Random sets, some with narrow values to force repeats.
  task automatic test_random_sets();
    int sent;
    int n;
    bit narrow;
    sent = 0;
    while (sent < 45) begin
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(3, 10);
      narrow = ($urandom_range(0, 2) == 0);
      no_gaps = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < n; i++)
        send_element(narrow ? $signed($urandom_range(0, 6)) - 3 : $urandom(), i == n - 1);
      sent += n;
      if ($urandom_range(0, 4) == 0) wait_drained();
    end
    no_gaps = 1'b0;
  endtask

  initial begin
    rst_n      = 1'b0;
    start      = 1'b0;
    in_value   = '0;
    in_is_last = 1'b0;
    mismatches = 0;
    cycles     = 0;
    no_gaps    = 1'b0;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_store_full();
    test_random_sets();
    wait_drained();
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
